>>> design/btc_pkg.sv
// Shared types, constants and helper functions of the block transposition cipher.
// Used by every module of the design; depends on nothing.
`timescale 1ns / 1ps

package btc_pkg;

    // Block geometry.
    localparam int MAX_SIDE = 8;
    localparam int CELLS    = MAX_SIDE * MAX_SIDE;
    localparam int IDX_W    = $clog2(CELLS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int ROW_W    = $clog2(MAX_SIDE);
    localparam int SIDE_W   = 4;

    // Two blocks in storage: one filling, one reading out.
    localparam int BANKS       = 2;
    localparam int ADDR_W      = IDX_W + 1;
    localparam int QUEUE_DEPTH = BANKS;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Padding character.
    localparam logic [7:0] PAD_CHAR = 8'h20;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 4'd8;
    localparam logic REG_SIDE  = 1'b0;
    localparam logic REG_STRIP = 1'b1;

    typedef struct packed {
        logic [SIDE_W-1:0] side;
        logic              strip;
    } btc_cfg_t;

    // Write port into the block storage.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } btc_wr_t;

    // One finished block waiting for readout.
    typedef struct packed {
        logic              bank;
        logic [SIDE_W-1:0] side;
        logic [CNT_W-1:0]  cells;
        logic [CNT_W-1:0]  count;
        logic              fin;
        logic              strip;
    } btc_desc_t;

    // Hands a bank back to the front once its readout has been issued.
    typedef struct packed {
        logic en;
        logic bank;
    } btc_release_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_EMIT
    } btc_state_t;

    // Side value as used: zero acts as one, values above the maximum are clamped.
    function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] s);
        logic [SIDE_W-1:0] n;
        if (s == '0)
            n = SIDE_W'(1);
        else if (s > SIDE_W'(MAX_SIDE))
            n = SIDE_W'(MAX_SIDE);
        else
            n = s;
        return n;
    endfunction

    // Number of cells of a block with the given edge length.
    function automatic logic [CNT_W-1:0] cells_of(input logic [SIDE_W-1:0] n);
        logic [2*SIDE_W-1:0] p;
        p = {{SIDE_W{1'b0}}, n} * {{SIDE_W{1'b0}}, n};
        return p[CNT_W-1:0];
    endfunction

endpackage

>>> design/btc_front.sv
// Front part: accepts message bytes, writes them into the current bank and
// closes a block when it is full or final. Depends on btc_pkg.
`timescale 1ns / 1ps

module btc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  btc_pkg::btc_cfg_t     cfg,
    input  logic                  start,
    input  logic [7:0]            data_byte,
    input  logic                  is_final,
    output logic                  busy,
    output btc_pkg::btc_wr_t      wr,
    output logic                  push,
    output btc_pkg::btc_desc_t    desc,
    input  btc_pkg::btc_release_t rel
);
    import btc_pkg::*;

    logic [IDX_W-1:0] fill_reg, fill_next;
    logic             wbank_reg, wbank_next;
    logic [BANKS-1:0] bank_busy_reg, bank_busy_next;

    logic [SIDE_W-1:0] n;
    logic [CNT_W-1:0]  cells;
    logic [CNT_W-1:0]  cnt1;
    logic              accept;
    logic              in_block;
    logic              flush;

    // Classify the incoming item against the current block size.
    always_comb
    begin
        n        = eff_side(cfg.side);
        cells    = cells_of(n);
        busy     = bank_busy_reg[wbank_reg];
        accept   = start && !busy;
        cnt1     = {1'b0, fill_reg} + CNT_W'(1);
        in_block = {1'b0, fill_reg} < cells;
        flush    = (cnt1 >= cells) || is_final;

        wr.en    = accept && in_block;
        wr.addr  = {wbank_reg, fill_reg};
        wr.data  = data_byte;

        push       = accept && flush;
        desc.bank  = wbank_reg;
        desc.side  = n;
        desc.cells = cells;
        desc.count = (cnt1 < cells) ? cnt1 : cells;
        desc.fin   = is_final;
        desc.strip = cfg.strip;
    end

    // Fill count, bank selection and bank ownership.
    always_comb
    begin
        fill_next      = fill_reg;
        wbank_next     = wbank_reg;
        bank_busy_next = bank_busy_reg;
        if (accept)
            fill_next = flush ? '0 : cnt1[IDX_W-1:0];
        if (rel.en)
            bank_busy_next[rel.bank] = 1'b0;
        if (push)
        begin
            bank_busy_next[wbank_reg] = 1'b1;
            wbank_next                = ~wbank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            wbank_reg     <= 1'b0;
            bank_busy_reg <= '0;
        end
        else
        begin
            fill_reg      <= fill_next;
            wbank_reg     <= wbank_next;
            bank_busy_reg <= bank_busy_next;
        end
    end

endmodule

>>> design/btc_queue.sv
// Short queue of closed blocks between the front and the back part.
// Depends on btc_pkg; the depth is a power of two.
`timescale 1ns / 1ps

module btc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  btc_pkg::btc_desc_t push_data,
    input  logic               pop,
    output logic               valid,
    output logic               full,
    output btc_pkg::btc_desc_t head
);
    import btc_pkg::*;

    btc_desc_t         entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    // Status and pointer updates.
    always_comb
    begin
        valid      = count_reg != '0;
        full       = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
        head       = entries_reg[rptr_reg];
        wptr_next  = push ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next  = pop ? rptr_reg + QPTR_W'(1) : rptr_reg;
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (QPTR_W + 1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wptr_reg] <= push_data;
    end

endmodule

>>> design/btc_back.sv
// Back part: holds the two-bank block storage and reads a closed block out
// column by column, with a scan pass for trailing spaces. Depends on btc_pkg.
`timescale 1ns / 1ps

module btc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  btc_pkg::btc_wr_t      wr,
    input  logic                  q_valid,
    input  btc_pkg::btc_desc_t    q_head,
    output logic                  pop,
    output btc_pkg::btc_release_t rel,
    output logic [7:0]            out_byte,
    output logic                  out_final,
    output logic                  strobe
);
    import btc_pkg::*;

    logic [7:0] mem [BANKS*CELLS];
    logic [7:0] rdata_reg;

    btc_state_t       state_reg, state_next;
    btc_desc_t        desc_reg, desc_next;
    logic [IDX_W-1:0] r_reg, r_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] last_reg, last_next;
    logic             found_reg, found_next;

    logic             p_valid_reg, p_valid_next;
    logic             p_emit_reg, p_emit_next;
    logic             p_pad_reg, p_pad_next;
    logic             p_last_reg, p_last_next;
    logic [IDX_W-1:0] p_pos_reg, p_pos_next;

    logic [ADDR_W-1:0] rd_addr;
    logic              issue;
    logic              row_wrap;
    logic [CNT_W-1:0]  scan_end;
    logic [CNT_W-1:0]  emit_end;
    logic [7:0]        p_byte;

    // Block storage: written by the front, read here with registered data.
    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        rdata_reg <= mem[rd_addr];
    end

    // Cells at or beyond the fill count of the block read as padding.
    assign p_byte = p_pad_reg ? PAD_CHAR : rdata_reg;

    // Readout sequencer: walks rows inside each column.
    always_comb
    begin
        state_next = state_reg;
        desc_next  = desc_reg;
        r_next     = r_reg;
        addr_next  = addr_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        last_next  = last_reg;
        found_next = found_reg;
        pop        = 1'b0;
        rel.en     = 1'b0;
        rel.bank   = desc_reg.bank;
        issue      = 1'b0;

        rd_addr  = {desc_reg.bank, addr_reg};
        row_wrap = {1'b0, row_reg} == (desc_reg.side - SIDE_W'(1));
        scan_end = desc_reg.cells - CNT_W'(1);
        if (desc_reg.fin && desc_reg.strip)
            emit_end = found_reg ? {1'b0, last_reg} : '0;
        else
            emit_end = scan_end;

        p_pad_next  = {1'b0, addr_reg} >= desc_reg.count;
        p_pos_next  = r_reg;
        p_last_next = desc_reg.fin && ({1'b0, r_reg} == emit_end);
        p_emit_next = state_reg == BK_EMIT;

        // Track the last non-space position seen during the scan pass.
        if (p_valid_reg && !p_emit_reg && p_byte != PAD_CHAR)
        begin
            found_next = 1'b1;
            last_next  = p_pos_reg;
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    desc_next  = q_head;
                    r_next     = '0;
                    addr_next  = '0;
                    row_next   = '0;
                    col_next   = '0;
                    found_next = 1'b0;
                    state_next = (q_head.fin && q_head.strip) ? BK_SCAN : BK_EMIT;
                end
            end
            BK_SCAN, BK_EMIT:
            begin
                issue  = 1'b1;
                r_next = r_reg + IDX_W'(1);
                if (row_wrap)
                begin
                    row_next  = '0;
                    col_next  = col_reg + ROW_W'(1);
                    addr_next = IDX_W'(col_reg) + IDX_W'(1);
                end
                else
                begin
                    row_next  = row_reg + ROW_W'(1);
                    addr_next = addr_reg + IDX_W'(desc_reg.side);
                end
                if (state_reg == BK_SCAN)
                begin
                    if ({1'b0, r_reg} == scan_end)
                        state_next = BK_DRAIN;
                end
                else if ({1'b0, r_reg} == emit_end)
                begin
                    rel.en     = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            BK_DRAIN:
            begin
                r_next     = '0;
                addr_next  = '0;
                row_next   = '0;
                col_next   = '0;
                state_next = BK_EMIT;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        p_valid_next = issue;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            p_valid_reg <= 1'b0;
            p_emit_reg  <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_valid_reg <= p_valid_next;
            p_emit_reg  <= p_emit_next;
            found_reg   <= found_next;
        end
    end

    // Payload and counter registers.
    always_ff @(posedge clk)
    begin
        desc_reg   <= desc_next;
        r_reg      <= r_next;
        addr_reg   <= addr_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        last_reg   <= last_next;
        p_pad_reg  <= p_pad_next;
        p_last_reg <= p_last_next;
        p_pos_reg  <= p_pos_next;
    end

    // Result ports.
    assign strobe    = p_valid_reg && p_emit_reg;
    assign out_byte  = p_byte;
    assign out_final = strobe && p_last_reg;

endmodule

>>> design/block_transposition_cipher_top.sv
// Top level of the block transposition cipher: configuration registers and
// the front, queue and back parts. Depends on btc_pkg, btc_front, btc_queue, btc_back.
`timescale 1ns / 1ps

// Bytes are taken one per cycle (start high, busy low) into one of two block
// banks; a block closes when side*side bytes have arrived or a byte marked
// final arrives, and then reads out column by column, one byte per cycle on
// strobe, once the back part is idle. The back part passes through its idle
// state between blocks; a final block in strip mode first runs a scan pass
// through the bank read port and a drain state, then emits up to its last
// non-space byte. Input and readout overlap as long as a bank is free; busy
// rises only when both banks hold blocks whose readout has not yet been fully
// issued. The receiver must take every result in the cycle it is shown. No
// clearing pass is needed after reset: cells not written in the current block
// are read as spaces by the fill count.
module block_transposition_cipher_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [7:0]                    data_byte,
    input  logic                          is_final,
    output logic [7:0]                    out_byte,
    output logic                          out_final,
    output logic                          strobe,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [btc_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import btc_pkg::*;

    logic [SIDE_W-1:0] side_reg;
    logic              strip_reg;
    logic              cfg_wr;

    btc_cfg_t     cfg;
    btc_wr_t      wr;
    btc_desc_t    desc;
    btc_desc_t    q_head;
    btc_release_t rel;
    logic         q_push;
    logic         q_pop;
    logic         q_valid;
    logic         q_full;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg  <= SIDE_RESET;
            strip_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_SIDE:  side_reg  <= pwdata[SIDE_W-1:0];
                REG_STRIP: strip_reg <= pwdata[0];
                default:   side_reg  <= side_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SIDE:  prdata = {{(32 - SIDE_W){1'b0}}, side_reg};
            REG_STRIP: prdata = {31'b0, strip_reg};
            default:   prdata = '0;
        endcase
    end

    assign cfg.side  = side_reg;
    assign cfg.strip = strip_reg;

    btc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .start     (start),
        .data_byte (data_byte),
        .is_final  (is_final),
        .busy      (busy),
        .wr        (wr),
        .push      (q_push),
        .desc      (desc),
        .rel       (rel)
    );

    btc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (desc),
        .pop       (q_pop),
        .valid     (q_valid),
        .full      (q_full),
        .head      (q_head)
    );

    btc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .pop       (q_pop),
        .rel       (rel),
        .out_byte  (out_byte),
        .out_final (out_final),
        .strobe    (strobe)
    );

`ifndef NO_ASSERTIONS
    // A closed block always finds room in the queue.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("block closed while the queue is full");

    // The back part only takes a block that is waiting.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // No byte is written while the current bank is still under readout.
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !wr.en)
        else $error("write into a bank that is being read out");
`endif

endmodule
